// File: sv/efr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// efr_pkg - shared definitions for the escaped frame receiver
// Byte codes, result kinds, queue entry layout and the CRC-16/CCITT byte step.
// ============================================================================

package efr_pkg;

   // Framing bytes on the serial line.
   localparam logic [7:0] BYTE_START = 8'hF0;
   localparam logic [7:0] BYTE_END   = 8'hF1;
   localparam logic [7:0] BYTE_ESC   = 8'hF2;

   // CRC-16/CCITT, MSB first, no final xor.
   localparam logic [15:0] CRC_PRESET = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'h1021;

   // A byte count of all ones marks the receiver as idle between frames.
   localparam logic [7:0] COUNT_IDLE = 8'hFF;

   localparam int DEFAULT_FRAME_CAPACITY = 128;
   localparam int DEFAULT_QUEUE_DEPTH    = 2;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_GOOD    = 2'd1,
      KIND_BAD     = 2'd2,
      KIND_CHECK   = 2'd3
   } kind_type;

   // Operations handed from the front end to the frame engine.
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_END   = 2'd1,
      OP_DATA  = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } qentry_type;

   // One full byte step of the CRC, eight shifts of a 16-bit word.
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// File: sv/efr_front.sv
`timescale 1ns / 1ps
// ============================================================================
// efr_front - byte classifier
// Strips escape bytes, restores escaped bytes and turns each remaining byte
// into a start, end or data operation for the frame engine.
// ============================================================================

module efr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                q_full,
   output logic                q_push,
   output efr_pkg::qentry_type q_entry
);

   logic esc_ff;
   logic esc_in;
   logic accept;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // The escape flag follows every accepted byte, framing bytes included.
   assign esc_in = accept ? (req_tdata == efr_pkg::BYTE_ESC) : esc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff <= 1'b0;
      end else begin
         esc_ff <= esc_in;
      end
   end

   always_comb begin
      q_entry.data = 8'h00;
      q_push       = 1'b0;
      case (req_tdata)
         efr_pkg::BYTE_START: begin
            q_entry.op = efr_pkg::OP_START;
            q_push     = accept;
         end
         efr_pkg::BYTE_END: begin
            q_entry.op = efr_pkg::OP_END;
            q_push     = accept;
         end
         efr_pkg::BYTE_ESC: begin
            // Escape bytes only set the flag and are dropped here.
            q_entry.op = efr_pkg::OP_DATA;
         end
         default: begin
            q_entry.op   = efr_pkg::OP_DATA;
            q_entry.data = esc_ff ? ~req_tdata : req_tdata;
            q_push       = accept;
         end
      endcase
   end

endmodule

// File: sv/efr_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// efr_queue - short operation queue
// Register-based FIFO that decouples the classifier from the frame engine.
// ============================================================================

module efr_queue #(
   parameter int DEPTH = efr_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  efr_pkg::qentry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output efr_pkg::qentry_type head
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   efr_pkg::qentry_type entries_ff [DEPTH];
   logic [IDX_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign valid   = (count_ff != '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The occupancy never exceeds the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy above depth");

   // The front end never offers an operation into a full queue.
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   // The frame engine only takes an operation that is there.
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      !(pop && !valid))
      else $error("pop from empty queue");

endmodule

// File: sv/efr_back.sv
`timescale 1ns / 1ps
// ============================================================================
// efr_back - frame engine
// Counts and CRC-checks frame bytes, delays payload by two bytes and issues
// the frame verdict into the response register.
// ============================================================================

module efr_back #(
   parameter int FRAME_CAPACITY = efr_pkg::DEFAULT_FRAME_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wren,
   input  logic [7:0]          csr_wdata,
   input  logic                q_valid,
   input  efr_pkg::qentry_type q_head,
   output logic                q_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   localparam logic [7:0] CAP = 8'(FRAME_CAPACITY);

   logic [7:0]        check_code_ff;
   logic [7:0]        count_ff, count_in;
   logic [15:0]       crc_ff, crc_in;
   logic [7:0]        older_ff, older_in;
   logic [7:0]        newer_ff, newer_in;
   logic              out_valid_ff, out_valid_in;
   efr_pkg::kind_type out_kind_ff, out_kind_in;
   logic [7:0]        out_data_ff, out_data_in;
   logic [7:0]        out_len_ff, out_len_in;
   logic              emit;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   always_comb begin
      count_in    = count_ff;
      crc_in      = crc_ff;
      older_in    = older_ff;
      newer_in    = newer_ff;
      emit        = 1'b0;
      out_kind_in = efr_pkg::KIND_PAYLOAD;
      out_data_in = 8'h00;
      out_len_in  = 8'h00;
      if (q_pop) begin
         case (q_head.op)
            efr_pkg::OP_START: begin
               count_in = 8'h00;
               crc_in   = efr_pkg::CRC_PRESET;
            end
            efr_pkg::OP_END: begin
               emit     = 1'b1;
               count_in = efr_pkg::COUNT_IDLE;
               if (count_ff == 8'd1 && newer_ff == check_code_ff) begin
                  out_kind_in = efr_pkg::KIND_CHECK;
               end else if (crc_ff != 16'h0000 || count_ff >= CAP || count_ff < 8'd2) begin
                  out_kind_in = efr_pkg::KIND_BAD;
               end else begin
                  out_kind_in = efr_pkg::KIND_GOOD;
                  out_len_in  = count_ff - 8'd2;
               end
            end
            efr_pkg::OP_DATA: begin
               if (count_ff < CAP) begin
                  if (count_ff >= 8'd2) begin
                     emit        = 1'b1;
                     out_data_in = older_ff;
                  end
                  older_in = newer_ff;
                  newer_in = q_head.data;
                  count_in = count_ff + 8'd1;
                  crc_in   = efr_pkg::crc16_byte(crc_ff, q_head.data);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_code_ff <= 8'h00;
         count_ff      <= 8'h00;
         crc_ff        <= 16'h0000;
         older_ff      <= 8'h00;
         newer_ff      <= 8'h00;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wren) begin
            check_code_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_kind_ff <= out_kind_in;
         out_data_ff <= out_data_in;
         out_len_ff  <= out_len_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {out_len_ff, out_data_ff};

   // The count stays within capacity, except for the idle mark.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP || count_ff == efr_pkg::COUNT_IDLE)
      else $error("byte count out of range");

   // A good frame never reports more payload than fits below capacity.
   a_good_length: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_kind_ff == efr_pkg::KIND_GOOD |-> out_len_ff <= CAP - 8'd2)
      else $error("good frame length exceeds capacity");

   // Fields that do not belong to the reported kind read as zero.
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_kind_ff == efr_pkg::KIND_PAYLOAD || out_data_ff == 8'h00) &&
                       (out_kind_ff == efr_pkg::KIND_GOOD || out_len_ff == 8'h00))
      else $error("unused response field not zero");

endmodule

// File: sv/escaped_frame_receiver_crc16.sv
`timescale 1ns / 1ps
// ============================================================================
// escaped_frame_receiver_crc16 - byte-stuffed frame receiver with CRC-16 check
// Removes start/end/escape framing, checks the CRC-16/CCITT of each frame,
// forwards payload bytes and reports one verdict per frame.
// ============================================================================
//
//   Channel   Direction  Contents
//   req_*     in         tdata[7:0] = rx_byte, one raw serial byte per request
//   rsp_*     out        tdata[7:0] = data_byte, tdata[15:8] = frame_length,
//                        tuser[1:0] = kind (payload, good, bad, check request)
//   csr_*     in         wdata[7:0] = check_msg_code, written when wren is high
//
// A request is taken every cycle while the operation queue is not full. A
// response passes through the operation queue and then the frame engine,
// which writes the response register.
// A stall on the response side fills the queue (two entries by default) and
// then drops req_tready; requests are never lost and the front keeps
// classifying while the queue has room.
// Reset is synchronous and clears the escape flag, queue, frame state and
// the check code register.
// ============================================================================

module escaped_frame_receiver_crc16 #(
   parameter int FRAME_CAPACITY = efr_pkg::DEFAULT_FRAME_CAPACITY,
   parameter int QUEUE_DEPTH    = efr_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // Configuration: check_msg_code.
   input  logic        csr_wren,
   input  logic [7:0]  csr_wdata,   // [7:0] check_msg_code
   // Received bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [15:8] frame_length
   output logic [1:0]  rsp_tuser    // [1:0] kind
);

   // Operations between the classifier and the frame engine. Escape bytes
   // never enter the queue; the classifier has already inverted the data byte
   // that follows one.
   logic                q_push;
   logic                q_full;
   logic                q_pop;
   logic                q_valid;
   efr_pkg::qentry_type q_push_entry;
   efr_pkg::qentry_type q_head;

   efr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_push_entry)
   );

   efr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head       (q_head)
   );

   // The frame engine pops one operation per cycle whenever its response
   // register is free or being drained, so the pipeline sustains full rate.
   efr_back #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wren   (csr_wren),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
